FILE: src/resp_command_deframer_top_macros.svh
// Assertion macros shared by the command deframer modules.
// Expects clk and rst to be visible in the module that expands them.
`ifndef RESP_COMMAND_DEFRAMER_TOP_MACROS_SVH
`define RESP_COMMAND_DEFRAMER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rcd_pkg.sv
// Shared types and constants of the command deframer.
// Used by every module of the block; depends on nothing.
package rcd_pkg;

  localparam logic [4:0] ARG_LIMIT    = 5'd16;
  localparam logic [9:0] LENGTH_LIMIT = 10'd512;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    CL_NEWLINE,
    CL_STAR,
    CL_DOLLAR,
    CL_BLANK,
    CL_PLUS,
    CL_MINUS,
    CL_DIGIT,
    CL_OTHER
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } item_t;

  typedef enum logic [2:0] {
    PH_STAR,
    PH_COUNT,
    PH_DOLLAR,
    PH_LEN,
    PH_DATA,
    PH_TR1,
    PH_TR2
  } phase_t;

  typedef enum logic [1:0] {
    K_FRAME,
    K_DATA,
    K_DONE,
    K_ERR
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE,
    E_NO_STAR,
    E_BAD_COUNT,
    E_NO_DOLLAR,
    E_BAD_LENGTH
  } err_t;

  typedef enum logic [1:0] {
    REG_MAX_ARG_COUNT,
    REG_MAX_ARG_LENGTH,
    REG_ALLOW_EMPTY
  } reg_index_t;

  typedef struct packed {
    logic [4:0] max_arg_count;
    logic [9:0] max_arg_length;
    logic       allow_empty;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  arg_index;
    logic [7:0]  payload_byte;
    logic        last_of_arg;
    logic [4:0]  arg_total;
    logic [15:0] bytes_used;
    err_t        error_code;
  } result_t;

endpackage

FILE: src/rcd_front.sv
// Front end: accepts raw bytes and tags each with its character class.
// Depends on rcd_pkg; feeds rcd_queue.
module rcd_front (
  input  logic          byte_valid,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          byte_stall,
  output logic          push,
  output rcd_pkg::item_t item
);

  rcd_pkg::byte_class_t cls;

  always_comb begin
    case (in_byte)
      rcd_pkg::CH_NEWLINE: cls = rcd_pkg::CL_NEWLINE;
      rcd_pkg::CH_STAR:    cls = rcd_pkg::CL_STAR;
      rcd_pkg::CH_DOLLAR:  cls = rcd_pkg::CL_DOLLAR;
      rcd_pkg::CH_PLUS:    cls = rcd_pkg::CL_PLUS;
      rcd_pkg::CH_MINUS:   cls = rcd_pkg::CL_MINUS;
      rcd_pkg::CH_SPACE,
      rcd_pkg::CH_TAB,
      rcd_pkg::CH_CR,
      rcd_pkg::CH_VT,
      rcd_pkg::CH_FF:      cls = rcd_pkg::CL_BLANK;
      default: begin
        if (in_byte >= rcd_pkg::CH_ZERO && in_byte <= rcd_pkg::CH_NINE) begin
          cls = rcd_pkg::CL_DIGIT;
        end else begin
          cls = rcd_pkg::CL_OTHER;
        end
      end
    endcase
  end

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;
  assign item.data  = in_byte;
  assign item.cls   = cls;

endmodule

FILE: src/rcd_queue.sv
// Short queue of classified bytes between the front end and the sequencer.
// Depends on rcd_pkg and the assertion macros.
`include "resp_command_deframer_top_macros.svh"
module rcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcd_pkg::item_t wr_item,
  input  logic           pop,
  output rcd_pkg::item_t rd_item,
  output logic           valid,
  output logic           full
);

  rcd_pkg::item_t                mem [rcd_pkg::QUEUE_DEPTH];
  logic [rcd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [rcd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [rcd_pkg::QUEUE_AW-1:0]  rd_ptr_next;
  logic [rcd_pkg::QUEUE_AW:0]    count;
  logic [rcd_pkg::QUEUE_AW:0]    count_plus;
  logic [rcd_pkg::QUEUE_AW:0]    depth_cnt;

  function automatic logic [rcd_pkg::QUEUE_AW-1:0] ptr_inc(
    input logic [rcd_pkg::QUEUE_AW-1:0] p
  );
    if (p == rcd_pkg::QUEUE_AW'(rcd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + rcd_pkg::QUEUE_AW'(1);
  endfunction

  assign rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
  assign count_plus  = count + (rcd_pkg::QUEUE_AW+1)'(1);
  assign depth_cnt   = (rcd_pkg::QUEUE_AW+1)'(rcd_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
    // take the incoming item as head when nothing older is left behind it
    if (push && rd_ptr_next == wr_ptr) begin
      rd_item <= wr_item;
    end else begin
      rd_item <= mem[rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      rd_ptr <= rd_ptr_next;
      case ({push, pop})
        2'b10:   count <= count_plus;
        2'b01:   count <= count - (rcd_pkg::QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign valid   = (count != '0);
  assign full    = (count == depth_cnt);

  `RCD_ASSERT_NOW(a_count_bound, 1'b1, count <= depth_cnt, "queue count above depth")
  `RCD_ASSERT_NEXT(a_count_grows, push && !pop, count == $past(count_plus), "count stuck on push")

endmodule

FILE: src/rcd_back.sv
// Back end: command sequencer and output register.
// Depends on rcd_pkg and the assertion macros; pops items from rcd_queue.
`include "resp_command_deframer_top_macros.svh"
module rcd_back (
  input  logic             clk,
  input  logic             rst,
  input  rcd_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  rcd_pkg::item_t   q_item,
  output logic             q_pop,
  input  logic             result_stall,
  output logic             result_valid,
  output rcd_pkg::result_t result
);

  rcd_pkg::phase_t phase;
  rcd_pkg::phase_t phase_next;
  logic [15:0] accum;
  logic [15:0] accum_next;
  logic        num_seen;
  logic        num_seen_next;
  logic        num_neg;
  logic        num_neg_next;
  logic        num_end;
  logic        num_end_next;
  logic [4:0]  args_expected;
  logic [4:0]  args_expected_next;
  logic [4:0]  args_done;
  logic [4:0]  args_done_next;
  logic [9:0]  bytes_left;
  logic [9:0]  bytes_left_next;
  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  rcd_pkg::result_t res_next;

  logic [4:0]  cnt_lim;
  logic [9:0]  len_lim;
  logic [15:0] byte_count_inc;
  logic [19:0] acc_prod;
  logic [15:0] acc_digit;
  logic        num_negative;
  logic        count_bad;
  logic        len_bad;
  logic [4:0]  args_done_inc;
  logic [9:0]  bytes_left_dec;
  logic        is_nl;

  assign q_pop = q_valid && (!result_valid || !result_stall);
  assign is_nl = (q_item.cls == rcd_pkg::CL_NEWLINE);

  assign cnt_lim = (cfg.max_arg_count < rcd_pkg::ARG_LIMIT) ? cfg.max_arg_count
                                                            : rcd_pkg::ARG_LIMIT;
  assign len_lim = (cfg.max_arg_length < rcd_pkg::LENGTH_LIMIT) ? cfg.max_arg_length
                                                                : rcd_pkg::LENGTH_LIMIT;
  assign byte_count_inc = (byte_count != 16'hFFFF) ? byte_count + 16'd1 : byte_count;

  // accum * 10 + digit, clamped to 16 bits
  assign acc_prod  = ({4'b0, accum} << 3) + ({4'b0, accum} << 1)
                   + {16'b0, q_item.data[3:0]};
  assign acc_digit = (acc_prod > 20'h0FFFF) ? 16'hFFFF : acc_prod[15:0];

  assign num_negative = num_neg && (accum != 16'd0);
  assign count_bad = num_negative || (accum == 16'd0) || (accum > {11'b0, cnt_lim});
  assign len_bad   = num_negative || (accum > {6'b0, len_lim})
                   || ((accum == 16'd0) && !cfg.allow_empty);
  assign args_done_inc  = args_done + 5'd1;
  assign bytes_left_dec = (bytes_left != 10'd0) ? bytes_left - 10'd1 : 10'd0;

  always_comb begin
    phase_next = phase;
    if (q_pop) begin
      case (phase)
        rcd_pkg::PH_COUNT: begin
          if (is_nl) begin
            phase_next = count_bad ? rcd_pkg::PH_STAR : rcd_pkg::PH_DOLLAR;
          end
        end
        rcd_pkg::PH_DOLLAR: begin
          phase_next = (q_item.cls == rcd_pkg::CL_DOLLAR) ? rcd_pkg::PH_LEN
                                                          : rcd_pkg::PH_STAR;
        end
        rcd_pkg::PH_LEN: begin
          if (is_nl) begin
            if (len_bad) begin
              phase_next = rcd_pkg::PH_STAR;
            end else if (accum[9:0] != 10'd0) begin
              phase_next = rcd_pkg::PH_DATA;
            end else begin
              phase_next = rcd_pkg::PH_TR1;
            end
          end
        end
        rcd_pkg::PH_DATA: begin
          if (bytes_left_dec == 10'd0) begin
            phase_next = rcd_pkg::PH_TR1;
          end
        end
        rcd_pkg::PH_TR1: phase_next = rcd_pkg::PH_TR2;
        rcd_pkg::PH_TR2: begin
          phase_next = (args_done_inc == args_expected) ? rcd_pkg::PH_STAR
                                                        : rcd_pkg::PH_DOLLAR;
        end
        default: begin
          phase_next = (q_item.cls == rcd_pkg::CL_STAR) ? rcd_pkg::PH_COUNT
                                                        : rcd_pkg::PH_STAR;
        end
      endcase
    end
  end

  always_comb begin
    accum_next         = accum;
    num_seen_next      = num_seen;
    num_neg_next       = num_neg;
    num_end_next       = num_end;
    args_expected_next = args_expected;
    args_done_next     = args_done;
    bytes_left_next    = bytes_left;
    byte_count_next    = byte_count_inc;
    res_next           = '0;
    res_next.kind       = rcd_pkg::K_FRAME;
    res_next.error_code = rcd_pkg::E_NONE;

    case (phase)
      rcd_pkg::PH_COUNT,
      rcd_pkg::PH_LEN: begin
        if (!is_nl) begin
          // atoi-style digit reader; stops at the first non-digit
          if (!num_end) begin
            if (!num_seen && q_item.cls == rcd_pkg::CL_BLANK) begin
              num_seen_next = 1'b0;
            end else if (!num_seen && (q_item.cls == rcd_pkg::CL_PLUS ||
                                       q_item.cls == rcd_pkg::CL_MINUS)) begin
              num_seen_next = 1'b1;
              num_neg_next  = (q_item.cls == rcd_pkg::CL_MINUS);
            end else if (q_item.cls == rcd_pkg::CL_DIGIT) begin
              num_seen_next = 1'b1;
              accum_next    = acc_digit;
            end else begin
              num_seen_next = 1'b1;
              num_end_next  = 1'b1;
            end
          end
        end else if (phase == rcd_pkg::PH_COUNT) begin
          if (count_bad) begin
            res_next.kind       = rcd_pkg::K_ERR;
            res_next.error_code = rcd_pkg::E_BAD_COUNT;
          end else begin
            args_expected_next = accum[4:0];
            args_done_next     = 5'd0;
          end
        end else begin
          if (len_bad) begin
            res_next.kind       = rcd_pkg::K_ERR;
            res_next.error_code = rcd_pkg::E_BAD_LENGTH;
          end else begin
            bytes_left_next = accum[9:0];
          end
        end
      end
      rcd_pkg::PH_DOLLAR: begin
        if (q_item.cls == rcd_pkg::CL_DOLLAR) begin
          accum_next    = 16'd0;
          num_seen_next = 1'b0;
          num_neg_next  = 1'b0;
          num_end_next  = 1'b0;
        end else begin
          res_next.kind       = rcd_pkg::K_ERR;
          res_next.error_code = rcd_pkg::E_NO_DOLLAR;
        end
      end
      rcd_pkg::PH_DATA: begin
        res_next.kind         = rcd_pkg::K_DATA;
        res_next.arg_index    = args_done[3:0];
        res_next.payload_byte = q_item.data;
        res_next.last_of_arg  = (bytes_left <= 10'd1);
        bytes_left_next       = bytes_left_dec;
      end
      rcd_pkg::PH_TR1: begin
        res_next.kind = rcd_pkg::K_FRAME;
      end
      rcd_pkg::PH_TR2: begin
        args_done_next = args_done_inc;
        if (args_done_inc == args_expected) begin
          res_next.kind       = rcd_pkg::K_DONE;
          res_next.arg_total  = args_done_inc;
          res_next.bytes_used = byte_count_inc;
        end
      end
      default: begin
        if (q_item.cls == rcd_pkg::CL_STAR) begin
          accum_next    = 16'd0;
          num_seen_next = 1'b0;
          num_neg_next  = 1'b0;
          num_end_next  = 1'b0;
        end else begin
          res_next.kind       = rcd_pkg::K_ERR;
          res_next.error_code = rcd_pkg::E_NO_STAR;
        end
      end
    endcase

    // drop all command state after completion or an error
    if (res_next.kind == rcd_pkg::K_ERR || res_next.kind == rcd_pkg::K_DONE) begin
      accum_next         = 16'd0;
      num_seen_next      = 1'b0;
      num_neg_next       = 1'b0;
      num_end_next       = 1'b0;
      args_expected_next = 5'd0;
      args_done_next     = 5'd0;
      bytes_left_next    = 10'd0;
      byte_count_next    = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rcd_pkg::PH_STAR;
      accum         <= 16'd0;
      num_seen      <= 1'b0;
      num_neg       <= 1'b0;
      num_end       <= 1'b0;
      args_expected <= 5'd0;
      args_done     <= 5'd0;
      bytes_left    <= 10'd0;
      byte_count    <= 16'd0;
    end else if (q_pop) begin
      phase         <= phase_next;
      accum         <= accum_next;
      num_seen      <= num_seen_next;
      num_neg       <= num_neg_next;
      num_end       <= num_end_next;
      args_expected <= args_expected_next;
      args_done     <= args_done_next;
      bytes_left    <= bytes_left_next;
      byte_count    <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `RCD_ASSERT_NOW(a_done_total, result_valid && result.kind == rcd_pkg::K_DONE, result.arg_total != 5'd0, "completion with zero arguments")
  `RCD_ASSERT_NOW(a_data_left, phase == rcd_pkg::PH_DATA, bytes_left != 10'd0, "payload phase with no bytes left")
  `RCD_ASSERT_NOW(a_err_code, result_valid && result.kind != rcd_pkg::K_ERR, result.error_code == rcd_pkg::E_NONE, "error code on a non-error result")

endmodule

FILE: src/resp_command_deframer_top.sv
// Request command deframer: top level with configuration registers.
// Depends on rcd_pkg, rcd_front, rcd_queue and rcd_back.
//
// Usage: bytes of a '*N' / '$L' framed command enter on in_byte under
// byte_valid/byte_stall; an item is taken when byte_valid is high and
// byte_stall is low. Every byte yields exactly one result on the result
// channel (result_valid/result_stall): framing, payload with argument index
// and last flag, completion with argument count and bytes used, or an error.
// An accepted byte is registered at the queue head, then in the result
// register. Throughput: one byte per cycle unless result_stall holds it;
// the sequencer steps once per byte (times-ten count update, limit compares).
// Reset clears the queue and result_valid, sets max_arg_count 16,
// max_arg_length 512, allow_empty_args 1, and waits for '*'.
// When the receiver stalls, the result holds and up to four bytes collect
// in the queue; byte_stall rises once the queue is full.
// Configuration: cfg_write with cfg_index 0..2 writes one register; write
// only while the block is idle.
module resp_command_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [3:0]  arg_index,
  output logic [7:0]  payload_byte,
  output logic        last_of_arg,
  output logic [4:0]  arg_total,
  output logic [15:0] bytes_used,
  output logic [2:0]  error_code
);

  rcd_pkg::cfg_t    cfg;
  rcd_pkg::item_t   f_item;
  rcd_pkg::item_t   q_item;
  rcd_pkg::result_t result;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_arg_count  <= 5'd16;
      cfg.max_arg_length <= 10'd512;
      cfg.allow_empty    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        rcd_pkg::REG_MAX_ARG_COUNT:  cfg.max_arg_count  <= cfg_data[4:0];
        rcd_pkg::REG_MAX_ARG_LENGTH: cfg.max_arg_length <= cfg_data;
        rcd_pkg::REG_ALLOW_EMPTY:    cfg.allow_empty    <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  rcd_front u_front (
    .byte_valid (byte_valid),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .byte_stall (byte_stall),
    .push       (push),
    .item       (f_item)
  );

  rcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .valid   (q_valid),
    .full    (q_full)
  );

  rcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  assign kind         = result.kind;
  assign arg_index    = result.arg_index;
  assign payload_byte = result.payload_byte;
  assign last_of_arg  = result.last_of_arg;
  assign arg_total    = result.arg_total;
  assign bytes_used   = result.bytes_used;
  assign error_code   = result.error_code;

endmodule
